### rtl/core/ecp_pkg.sv
// ----------------------------------------------------------------------------
// ecp_pkg: shared types and constants of the escape command parser
// Transaction payloads, byte codes, result kinds and the parse phase encoding.
// ----------------------------------------------------------------------------
package ecp_pkg;

   typedef struct packed {
      logic [7:0]  byte_value;
      logic [15:0] cursor_col;
      logic [15:0] cursor_row;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [7:0]         char_code;
      logic signed [31:0] arg_a;
      logic signed [31:0] arg_b;
      logic signed [31:0] arg_c;
   } rsp_type;

   // Byte codes
   localparam logic [7:0] BYTE_ESC   = 8'h1B;
   localparam logic [7:0] BYTE_BEL   = 8'h07;
   localparam logic [7:0] BYTE_NUL   = 8'h00;
   localparam logic [7:0] BYTE_NL    = 8'h0A;
   localparam logic [7:0] BYTE_MOVE  = 8'h41;  // 'A'
   localparam logic [7:0] BYTE_QUIT  = 8'h51;  // 'Q'
   localparam logic [7:0] BYTE_TEST  = 8'h5A;  // 'Z'
   localparam logic [7:0] BYTE_SEMI  = 8'h3B;  // ';'
   localparam logic [7:0] BYTE_MINUS = 8'h2D;  // '-'
   localparam logic [7:0] BYTE_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] BYTE_NINE  = 8'h39;  // '9'

   // Result kinds; command codes share the same encoding
   localparam logic [1:0] KIND_TYPE = 2'd0;
   localparam logic [1:0] KIND_MOVE = 2'd1;
   localparam logic [1:0] KIND_QUIT = 2'd2;
   localparam logic [1:0] KIND_TEST = 2'd3;
   localparam logic [1:0] CMD_NONE  = 2'd0;

   localparam logic [1:0] MOVE_PARAMS = 2'd2;
   localparam logic [1:0] TEST_PARAMS = 2'd3;

   localparam logic [7:0] LINE_ADVANCE_RESET = 8'd2;

   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_CMD    = 6'b000010,
      PH_START  = 6'b000100,
      PH_SIGN   = 6'b001000,
      PH_DIGITS = 6'b010000,
      PH_SKIP   = 6'b100000
   } phase_type;

endpackage

### rtl/core/escape_command_parser_core.sv
// ----------------------------------------------------------------------------
// escape_command_parser_core: byte-stream escape command parser
// Input register, parse engine and result register with valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one byte with the current cursor column and row per
//   transaction. rsp_* returns at most one result per byte: a typed
//   character, an absolute move, a quit or a test command with three
//   parameters. Bytes inside an escape sequence return nothing until the
//   BEL or NUL terminator, which returns a known command.
//   csr_* writes line_advance (rows added on a newline); write it only while
//   no transaction is in flight. csr_ready is always high.
//   Path: byte into the input register, its result into the result register.
//   Throughput: one byte per cycle unless the receiver stalls; the parse step is a
//   single pass of the engine between the input register and the result register.
//   Reset puts the parser outside any sequence, clears both registers and
//   sets line_advance to 2.
//   When the receiver stalls, the result register holds and the input
//   register takes one more byte; req_ready then drops until rsp_ready
//   returns.
// ----------------------------------------------------------------------------
module escape_command_parser_core #(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ecp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ecp_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);
   import ecp_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   req_type    s1_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;
   logic [7:0] line_adv_ff, line_adv_in;
   logic       adv;
   logic       fire;
   logic       emit;
   rsp_type    result;

   // Output register free or draining this cycle
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign fire      = s1_valid_ff && adv;
   assign req_ready = !s1_valid_ff || adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign s1_valid_in  = (req_valid && req_ready) ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = adv ? (fire && emit) : rsp_valid_ff;
   assign line_adv_in  = csr_valid ? csr_data : line_adv_ff;

   ecp_engine #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .step         (fire),
      .item         (s1_data_ff),
      .line_advance (line_adv_ff),
      .emit         (emit),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         line_adv_ff  <= LINE_ADVANCE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         line_adv_ff  <= line_adv_in;
      end
   end

   // Payload registers: load on transaction, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (fire && emit) begin
         rsp_data_ff <= result;
      end
   end

   a_free_output_takes_input: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled while result register is empty");

   a_stalled_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("input register lost a byte during a stall");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_ready)) |-> $past(fire && emit))
      else $error("result appeared without an engine step");

endmodule

### rtl/core/ecp_engine.sv
// ----------------------------------------------------------------------------
// ecp_engine: parse state and per-byte decode
// Holds the sequence state and computes next state and result for one byte.
// ----------------------------------------------------------------------------
module ecp_engine #(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  ecp_pkg::req_type item,
   input  logic [7:0]       line_advance,
   output logic             emit,
   output ecp_pkg::rsp_type result
);
   import ecp_pkg::*;

   localparam int ExtWidth = (NUMBER_WIDTH > 32) ? NUMBER_WIDTH : 32;

   phase_type               phase_ff, phase_in;
   logic [1:0]              cmd_ff, cmd_in;
   logic [1:0]              pidx_ff, pidx_in;
   logic                    neg_ff, neg_in;
   logic [NUMBER_WIDTH-1:0] acc_ff, acc_in;
   logic [31:0]             p0_ff, p0_in;
   logic [31:0]             p1_ff, p1_in;
   logic [31:0]             p2_ff, p2_in;
   logic [15:0]             lcol_ff, lcol_in;
   logic [15:0]             lrow_ff, lrow_in;

   logic [7:0]              b;
   logic                    is_digit;
   logic [3:0]              digit;
   logic                    is_term;
   logic [1:0]              count;
   logic [NUMBER_WIDTH-1:0] fin_mag;
   logic [ExtWidth-1:0]     fin_ext;
   logic [31:0]             fin_val;

   assign b        = item.byte_value;
   assign is_digit = (b >= BYTE_ZERO) && (b <= BYTE_NINE);
   assign digit    = 4'(b - BYTE_ZERO);
   assign is_term  = (b == BYTE_BEL) || (b == BYTE_NUL);
   assign count    = (cmd_ff == KIND_MOVE) ? MOVE_PARAMS :
                     (cmd_ff == KIND_TEST) ? TEST_PARAMS : 2'd0;

   // Finished parameter: negate if signed, sign-extend from the number width
   assign fin_mag = neg_ff ? (NUMBER_WIDTH'(0) - acc_ff) : acc_ff;
   assign fin_ext = ExtWidth'($signed(fin_mag));
   assign fin_val = fin_ext[31:0];

   always_comb begin
      logic       do_start;
      logic       do_fill;
      logic       do_skip;
      logic       emit_cmd;
      logic [1:0] idx_v;

      do_start = 1'b0;
      do_fill  = 1'b0;
      do_skip  = 1'b0;
      emit_cmd = 1'b0;
      idx_v    = pidx_ff;

      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      p0_in    = p0_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      lcol_in  = lcol_ff;
      lrow_in  = lrow_ff;
      emit     = 1'b0;
      result   = '0;

      case (phase_ff)
         PH_IDLE: begin
            if (b == BYTE_ESC) begin
               phase_in = PH_CMD;
            end else if (b == BYTE_NL) begin
               emit               = 1'b1;
               result.result_kind = KIND_MOVE;
               result.arg_b       = 32'(item.cursor_row) + 32'(line_advance);
            end else begin
               emit               = 1'b1;
               result.result_kind = KIND_TYPE;
               result.char_code   = b;
            end
         end
         PH_CMD: begin
            idx_v  = 2'd0;
            neg_in = 1'b0;
            case (b)
               BYTE_MOVE: begin
                  cmd_in   = KIND_MOVE;
                  lcol_in  = item.cursor_col;
                  lrow_in  = item.cursor_row;
                  phase_in = PH_START;
               end
               BYTE_TEST: begin
                  cmd_in   = KIND_TEST;
                  phase_in = PH_START;
               end
               BYTE_QUIT: begin
                  cmd_in   = KIND_QUIT;
                  phase_in = PH_SKIP;
               end
               default: begin
                  cmd_in   = CMD_NONE;
                  phase_in = PH_SKIP;
               end
            endcase
         end
         PH_START: begin
            do_start = 1'b1;
         end
         PH_SIGN: begin
            if (is_digit) begin
               acc_in   = NUMBER_WIDTH'(digit);
               phase_in = PH_DIGITS;
            end else begin
               do_fill = 1'b1;
               do_skip = 1'b1;
            end
         end
         PH_DIGITS: begin
            if (is_digit) begin
               // acc * 10 + digit, wrapping at the number width
               acc_in = {acc_ff[NUMBER_WIDTH-4:0], 3'b000}
                      + {acc_ff[NUMBER_WIDTH-2:0], 1'b0}
                      + NUMBER_WIDTH'(digit);
            end else begin
               case (idx_v)
                  2'd0:    p0_in = fin_val;
                  2'd1:    p1_in = fin_val;
                  2'd2:    p2_in = fin_val;
                  default: ;
               endcase
               idx_v = 2'(idx_v + 2'd1);
               if (b == BYTE_SEMI) begin
                  phase_in = (idx_v < count) ? PH_START : PH_SKIP;
               end else if (idx_v < count) begin
                  do_start = 1'b1;
               end else begin
                  do_skip = 1'b1;
               end
            end
         end
         default: begin
            do_skip = 1'b1;
         end
      endcase

      // Start of a parameter; the stopping byte still counts as terminator
      if (do_start) begin
         if (b == BYTE_MINUS) begin
            neg_in   = 1'b1;
            phase_in = PH_SIGN;
         end else if (is_digit) begin
            neg_in   = 1'b0;
            acc_in   = NUMBER_WIDTH'(digit);
            phase_in = PH_DIGITS;
         end else begin
            do_fill = 1'b1;
            do_skip = 1'b1;
         end
      end

      // Default this parameter and every later one
      if (do_fill) begin
         if (idx_v == 2'd0 && count > 2'd0) begin
            p0_in = (cmd_ff == KIND_MOVE) ? 32'(lcol_ff) : 32'd0;
         end
         if (idx_v <= 2'd1 && count > 2'd1) begin
            p1_in = (cmd_ff == KIND_MOVE) ? 32'(lrow_ff) : 32'd0;
         end
         if (idx_v <= 2'd2 && count > 2'd2) begin
            p2_in = 32'd0;
         end
         idx_v = count;
      end

      if (do_skip) begin
         if (is_term) begin
            phase_in = PH_IDLE;
            emit_cmd = (cmd_ff != CMD_NONE);
         end else begin
            phase_in = PH_SKIP;
         end
      end

      pidx_in = idx_v;

      if (emit_cmd) begin
         emit               = 1'b1;
         result.result_kind = cmd_ff;
         if (cmd_ff == KIND_MOVE || cmd_ff == KIND_TEST) begin
            result.arg_a = p0_in;
            result.arg_b = p1_in;
         end
         if (cmd_ff == KIND_TEST) begin
            result.arg_c = p2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cmd_ff   <= CMD_NONE;
         pidx_ff  <= 2'd0;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         p0_ff    <= '0;
         p1_ff    <= '0;
         p2_ff    <= '0;
         lcol_ff  <= '0;
         lrow_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         pidx_ff  <= pidx_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
         p0_ff    <= p0_in;
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
         lcol_ff  <= lcol_in;
         lrow_ff  <= lrow_in;
      end
   end

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("parse phase is not one-hot");

   a_param_phase_has_cmd: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_START || phase_ff == PH_SIGN || phase_ff == PH_DIGITS)
         |-> (cmd_ff == KIND_MOVE || cmd_ff == KIND_TEST))
      else $error("parameter phase without a parameterized command");

   a_param_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_START || phase_ff == PH_SIGN || phase_ff == PH_DIGITS)
         |-> (pidx_ff < count))
      else $error("parameter index beyond command parameter count");

endmodule

### sim/ecp_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecp_tb_pkg: result checker for the escape command parser testbench
// Tracks the parse state of the byte stream, queues the result each accepted
// byte should produce and compares arriving results field by field.
// ----------------------------------------------------------------------------
package ecp_tb_pkg;
   import ecp_pkg::*;

   class ecp_result_checker;
      rsp_type     pending_results[$];
      int unsigned error_count;
      int unsigned checked_count;
      int unsigned command_count;

      logic [7:0]  line_advance;
      phase_type   phase;
      logic [1:0]  command;
      logic [1:0]  param_index;
      logic        negative;
      logic [31:0] accumulator;
      logic [31:0] first_param;
      logic [31:0] second_param;
      logic [15:0] latched_col;
      logic [15:0] latched_row;

      function new();
         error_count   = 0;
         checked_count = 0;
         command_count = 0;
         line_advance  = LINE_ADVANCE_RESET;
         phase         = PH_IDLE;
         command       = CMD_NONE;
         param_index   = 2'd0;
         negative      = 1'b0;
         accumulator   = 32'd0;
         first_param   = 32'd0;
         second_param  = 32'd0;
         latched_col   = 16'd0;
         latched_row   = 16'd0;
      endfunction

      function void set_line_advance(logic [7:0] value);
         line_advance = value;
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      function void push_result(logic [1:0] kind, logic [7:0] ch,
                                logic [31:0] a_val, logic [31:0] b_val,
                                logic [31:0] c_val);
         rsp_type item;
         item.result_kind = kind;
         item.char_code   = ch;
         item.arg_a       = a_val;
         item.arg_b       = b_val;
         item.arg_c       = c_val;
         pending_results.push_back(item);
      endfunction

      function bit is_digit(logic [7:0] b);
         return b >= BYTE_ZERO && b <= BYTE_NINE;
      endfunction

      function logic [1:0] param_count();
         if (command == KIND_MOVE) return MOVE_PARAMS;
         if (command == KIND_TEST) return TEST_PARAMS;
         return 2'd0;
      endfunction

      // slot 2 is the accumulator itself
      function void store_param(int idx, logic [31:0] value);
         if (idx == 0) first_param = value;
         else if (idx == 1) second_param = value;
         else if (idx == 2) accumulator = value;
      endfunction

      function void fill_defaults();
         logic [1:0] count;
         count = param_count();
         for (int k = param_index; k < count; k++) begin
            if (command == KIND_MOVE)
               store_param(k, (k == 0) ? {16'h0000, latched_col} : {16'h0000, latched_row});
            else
               store_param(k, 32'd0);
         end
         param_index = count;
      endfunction

      function void finish_param();
         store_param(param_index, negative ? -accumulator : accumulator);
         param_index = param_index + 2'd1;
      endfunction

      function void skip_or_emit(logic [7:0] b);
         if (b != BYTE_BEL && b != BYTE_NUL) begin
            phase = PH_SKIP;
            return;
         end
         phase = PH_IDLE;
         case (command)
            KIND_MOVE: push_result(KIND_MOVE, 8'h00, first_param, second_param, 32'd0);
            KIND_QUIT: push_result(KIND_QUIT, 8'h00, 32'd0, 32'd0, 32'd0);
            KIND_TEST: push_result(KIND_TEST, 8'h00, first_param, second_param, accumulator);
            default: return;
         endcase
         command_count++;
      endfunction

      function void start_param(logic [7:0] b);
         if (b == BYTE_MINUS) begin
            negative = 1'b1;
            phase    = PH_SIGN;
         end else if (is_digit(b)) begin
            negative    = 1'b0;
            accumulator = 32'(b - BYTE_ZERO);
            phase       = PH_DIGITS;
         end else begin
            // malformed: this and every later parameter take defaults
            fill_defaults();
            skip_or_emit(b);
         end
      endfunction

      function void parse_byte(req_type r);
         logic [7:0] b;
         b = r.byte_value;
         case (phase)
            PH_IDLE: begin
               if (b == BYTE_ESC)
                  phase = PH_CMD;
               else if (b == BYTE_NL)
                  push_result(KIND_MOVE, 8'h00, 32'd0,
                              {16'h0000, r.cursor_row} + {24'h000000, line_advance}, 32'd0);
               else
                  push_result(KIND_TYPE, b, 32'd0, 32'd0, 32'd0);
            end
            PH_CMD: begin
               param_index = 2'd0;
               negative    = 1'b0;
               if (b == BYTE_MOVE) begin
                  command     = KIND_MOVE;
                  latched_col = r.cursor_col;
                  latched_row = r.cursor_row;
                  phase       = PH_START;
               end else if (b == BYTE_TEST) begin
                  command = KIND_TEST;
                  phase   = PH_START;
               end else if (b == BYTE_QUIT) begin
                  command = KIND_QUIT;
                  phase   = PH_SKIP;
               end else begin
                  command = CMD_NONE;
                  phase   = PH_SKIP;
               end
            end
            PH_START: start_param(b);
            PH_SIGN: begin
               if (is_digit(b)) begin
                  accumulator = 32'(b - BYTE_ZERO);
                  phase       = PH_DIGITS;
               end else begin
                  fill_defaults();
                  skip_or_emit(b);
               end
            end
            PH_DIGITS: begin
               if (is_digit(b)) begin
                  accumulator = accumulator * 32'd10 + 32'(b - BYTE_ZERO);
               end else begin
                  finish_param();
                  if (b == BYTE_SEMI)
                     phase = (param_index < param_count()) ? PH_START : PH_SKIP;
                  else if (param_index < param_count())
                     start_param(b);  // no separator: next parameter starts here
                  else
                     skip_or_emit(b);
               end
            end
            default: skip_or_emit(b);
         endcase
      endfunction

      function void compare_field(string name, logic signed [32:0] exp_val,
                                  logic signed [32:0] got_val);
         if (got_val !== exp_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, got_val);
            error_count++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         checked_count++;
         if (pending_results.size() == 0) begin
            $error("unexpected result: kind %0d char %0d args %0d %0d %0d",
                   got.result_kind, got.char_code, got.arg_a, got.arg_b, got.arg_c);
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("result_kind", want.result_kind, got.result_kind);
         compare_field("char_code", want.char_code, got.char_code);
         compare_field("arg_a", want.arg_a, got.arg_a);
         compare_field("arg_b", want.arg_b, got.arg_b);
         compare_field("arg_c", want.arg_c, got.arg_c);
      endfunction
   endclass

endpackage

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of escape_command_parser_core
// Drives a byte stream of plain text, newlines and escape sequences with
// random content through bursty valid/ready traffic, varies line_advance
// between phases and checks every result against a cycle-free parse model.
// ----------------------------------------------------------------------------
module tb;
   import ecp_pkg::*;
   import ecp_tb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 190;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_data;

   ecp_result_checker scoreboard = new();

   int unsigned cycle_count = 0;
   int unsigned bytes_sent  = 0;
   int          burst_left  = 0;
   bit          long_hold_req = 1'b0;

   escape_command_parser_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending",
                  cycle_count, scoreboard.pending());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) scoreboard.check_result(rsp_data);
   end

   // Receiver: changes its stall pattern every segment; a long hold-off
   // can be requested from the stimulus side.
   initial begin : rsp_side
      int mode;
      int seg_left;
      int hold_left;
      mode      = 0;
      seg_left  = 0;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = $urandom_range(60, 120);
         end
         if (seg_left == 0) begin
            mode     = $urandom_range(0, 3);
            seg_left = $urandom_range(20, 200);
         end
         seg_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (seg_left % 3 != 0);
            endcase
         end
      end
   end

   function automatic logic [15:0] pick_cursor();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic string decimal_text();
      longint unsigned mag;
      case ($urandom_range(0, 4))
         0: mag = $urandom_range(0, 9);
         1: mag = $urandom_range(0, 99999);
         2: mag = $urandom;
         3: mag = {$urandom, $urandom};  // wraps the accumulator
         default: begin
            case ($urandom_range(0, 3))
               0: mag = 64'd2147483647;
               1: mag = 64'd2147483648;
               2: mag = 64'd4294967295;
               default: mag = 64'd4294967296;
            endcase
         end
      endcase
      return $sformatf("%0d", mag);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic [15:0] col,
                            input logic [15:0] row);
      req_type item;
      item.byte_value = b;
      item.cursor_col = col;
      item.cursor_row = row;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      scoreboard.parse_byte(item);
      bytes_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // One chunk of the stream: a noise byte, a newline, a printable byte
   // or an escape sequence, mostly well formed.
   task automatic send_stream_chunk();
      logic [7:0] seq[$];
      string      digits;
      int         pick;
      int         nparams;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         seq.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 22) begin
         seq.push_back(BYTE_NL);
      end else if (pick < 30) begin
         seq.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else begin
         seq.push_back(BYTE_ESC);
         pick = $urandom_range(0, 99);
         if (pick < 40) seq.push_back(BYTE_MOVE);
         else if (pick < 75) seq.push_back(BYTE_TEST);
         else if (pick < 85) seq.push_back(BYTE_QUIT);
         else seq.push_back(8'($urandom_range(0, 255)));
         nparams = $urandom_range(0, 4);
         for (int i = 0; i < nparams; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               seq.push_back(8'($urandom_range(0, 255)));
            end else begin
               if ($urandom_range(0, 2) == 0) seq.push_back(BYTE_MINUS);
               digits = decimal_text();
               for (int j = 0; j < digits.len(); j++) seq.push_back(digits[j]);
            end
            if (i < nparams - 1) begin
               pick = $urandom_range(0, 9);
               if (pick < 8) seq.push_back(BYTE_SEMI);
               else if (pick == 8) seq.push_back(BYTE_MINUS);
            end
         end
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom_range(8, 255)));
         end
         // leave about one in ten open so later bytes get swallowed
         pick = $urandom_range(0, 9);
         if (pick < 5) seq.push_back(BYTE_BEL);
         else if (pick < 9) seq.push_back(BYTE_NUL);
      end
      foreach (seq[i]) send_byte(seq[i], pick_cursor(), pick_cursor());
   endtask

   task automatic send_random_stream(input int unsigned count);
      int unsigned target;
      target = bytes_sent + count;
      while (bytes_sent < target) send_stream_chunk();
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
      // trailing bytes that produce nothing may still be in the pipeline
      repeat (4) @(posedge clock);
   endtask

   task automatic write_line_advance(input logic [7:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      scoreboard.set_line_advance(value);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [7:0] directed[$];
      logic [7:0] settings[5];
      directed = '{
         // move with no separator between parameters
         BYTE_ESC, BYTE_MOVE, "5", BYTE_MINUS, "3", BYTE_BEL,
         // move with defaults taken from the latched cursor
         BYTE_ESC, BYTE_MOVE, BYTE_SEMI, BYTE_BEL,
         // malformed sign, then extra bytes before the terminator
         BYTE_ESC, BYTE_TEST, BYTE_MINUS, "x", "7", BYTE_BEL,
         BYTE_ESC, BYTE_QUIT, BYTE_NUL,
         // terminator taken as the command byte: nothing comes out
         BYTE_ESC, BYTE_BEL, BYTE_BEL
      };
      settings = '{8'd255, 8'd0, 8'($urandom_range(3, 254)), 8'd1,
                   8'($urandom_range(0, 255))};

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // typed extremes and a newline at the far corner, reset line_advance
      send_byte(BYTE_NUL, 16'h0000, 16'h0000);
      send_byte(8'hFF, 16'hFFFF, 16'hFFFF);
      send_byte(BYTE_NL, 16'hFFFF, 16'hFFFF);
      foreach (directed[i]) send_byte(directed[i], pick_cursor(), pick_cursor());
      wait_results_drained();

      foreach (settings[p]) begin
         write_line_advance(settings[p]);
         send_random_stream(PHASE_ITEMS);
         if (p == 1) long_hold_req = 1'b1;  // sender keeps offering meanwhile
         if (p == 3) wait_results_drained();
         send_random_stream(PHASE_ITEMS);
         wait_results_drained();
      end

      repeat (8) @(posedge clock);
      $display("%0d bytes sent, %0d results checked, %0d escape commands emitted",
               bytes_sent, scoreboard.checked_count, scoreboard.command_count);
      $display("line_advance settings: reset, %0d, %0d, %0d, %0d, %0d",
               settings[0], settings[1], settings[2], settings[3], settings[4]);
      if (scoreboard.error_count == 0 && scoreboard.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### sim.f
rtl/core/ecp_pkg.sv
rtl/core/ecp_engine.sv
rtl/core/escape_command_parser_core.sv
sim/ecp_tb_pkg.sv
sim/tb.sv
